// ===== src/qapd_pkg.sv =====
// Package for the quaternion attitude PD controller.
// Fixed-point formats, gain reset values, register indexes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qapd_pkg;

	localparam int QUAT_FRAC_BITS   = 14;
	localparam int GAIN_FRAC_BITS   = 12;
	localparam int RATE_FRAC_BITS   = 10;
	localparam int TORQUE_FRAC_BITS = 12;
	localparam int ACC_SHIFT = GAIN_FRAC_BITS + QUAT_FRAC_BITS + RATE_FRAC_BITS
		- TORQUE_FRAC_BITS;

	localparam logic [15:0] QUAT_ONE = 16'(1 << QUAT_FRAC_BITS);

	localparam int GAIN_ONE = 1 << GAIN_FRAC_BITS;
	localparam logic [15:0] PROP_XY_RST = 16'(2 * GAIN_ONE);
	localparam logic [15:0] PROP_Z_RST  = 16'((GAIN_ONE + 5) / 10);
	localparam logic [15:0] DAMP_XY_RST = 16'((4 * GAIN_ONE + 5) / 10);
	localparam logic [15:0] DAMP_Z_RST  = 16'((GAIN_ONE + 50) / 100);

	// Square root gives 31 result bits; the quotient needs 16 bits.
	localparam int ROOT_BITS = 31;
	localparam int DIV_BITS  = 16;
	localparam int NORM_LAT  = 4 + ROOT_BITS + 1 + DIV_BITS + 1;

	typedef enum logic [2:0] {
		REG_PROP_X = 3'd0,
		REG_PROP_Y = 3'd1,
		REG_PROP_Z = 3'd2,
		REG_DAMP_X = 3'd3,
		REG_DAMP_Y = 3'd4,
		REG_DAMP_Z = 3'd5
	} reg_idx_t;

	// Quaternion components w, x, y, z at index 0..3, each signed 16 bit.
	typedef logic [3:0][15:0] quat_t;

endpackage

`default_nettype wire

// ===== src/qapd_norm.sv =====
// Pipelined quaternion normalizer: squared norm, bit-per-stage square root
// and bit-per-stage division of each component. Uses qapd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qapd_norm import qapd_pkg::*; #(
	parameter int NQ     = 1,
	parameter int SIDE_W = 48
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire quat_t             in_q [NQ],
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_vld,
	output quat_t                  out_q [NQ],
	output logic [SIDE_W-1:0]      out_side
);

	typedef struct packed {
		logic [3:0][15:0] m;
		logic [3:0]       neg;
		logic [4:0]       h;
		logic             zero;
	} nmeta_t;

	logic              vld_s  [NORM_LAT];
	logic [SIDE_W-1:0] side_s [NORM_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NORM_LAT; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k < NORM_LAT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int k = 1; k < NORM_LAT; k++) side_s[k] <= side_s[k-1];
		end
	end

	assign out_vld  = vld_s[NORM_LAT-1];
	assign out_side = side_s[NORM_LAT-1];

	for (genvar l = 0; l < NQ; l++) begin : g_lane
		logic [3:0][15:0] mag;
		logic [3:0][15:0] m_s1;
		logic [3:0]       neg_s1;
		logic [3:0][31:0] sq_s1;
		logic [32:0]      n2_s2;
		logic [3:0][15:0] m_s2;
		logic [3:0]       neg_s2;
		logic [5:0]       msb;
		nmeta_t           meta_s3;
		logic [32:0]      n2_s3;
		nmeta_t           meta_s4;
		logic [61:0]      v_s4;
		logic [32:0]      rem_r  [ROOT_BITS];
		logic [30:0]      root_r [ROOT_BITS];
		logic [61:0]      v_r    [ROOT_BITS];
		nmeta_t           meta_r [ROOT_BITS];
		logic [3:0][31:0] drem_s5;
		logic [3:0][15:0] nlow_s5;
		logic [30:0]      r_s5;
		nmeta_t           meta_s5;
		logic [3:0][31:0] drem_d [DIV_BITS];
		logic [3:0][15:0] nlow_d [DIV_BITS];
		logic [3:0][15:0] quo_d  [DIV_BITS];
		logic [30:0]      r_d    [DIV_BITS];
		nmeta_t           meta_d [DIV_BITS];

		always_comb begin
			for (int c = 0; c < 4; c++) begin
				mag[c] = in_q[l][c][15] ? 16'(-in_q[l][c]) : in_q[l][c];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 4; c++) begin
					neg_s1[c] <= in_q[l][c][15];
					m_s1[c]   <= mag[c];
					sq_s1[c]  <= mag[c] * mag[c];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n2_s2  <= 33'(sq_s1[0]) + 33'(sq_s1[1]) + 33'(sq_s1[2]) + 33'(sq_s1[3]);
				m_s2   <= m_s1;
				neg_s2 <= neg_s1;
			end
		end

		always_comb begin
			msb = '0;
			for (int b = 0; b < 33; b++) begin
				if (n2_s2[b]) msb = 6'(b);
			end
		end

		// Scale by 4^h so the squared norm lands in [2^60, 2^62).
		always_ff @(posedge clk) begin
			if (en) begin
				n2_s3        <= n2_s2;
				meta_s3.m    <= m_s2;
				meta_s3.neg  <= neg_s2;
				meta_s3.h    <= 5'((7'd61 - 7'(msb)) >> 1);
				meta_s3.zero <= (n2_s2 == '0);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s4    <= 62'(n2_s3) << {meta_s3.h, 1'b0};
				meta_s4 <= meta_s3;
			end
		end

		for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
			logic [32:0] rem_i;
			logic [30:0] root_i;
			logic [61:0] v_i;
			nmeta_t      meta_i;
			logic [34:0] sh;
			logic [34:0] trial;

			if (k == 0) begin : g_first
				assign rem_i  = '0;
				assign root_i = '0;
				assign v_i    = v_s4;
				assign meta_i = meta_s4;
			end else begin : g_next
				assign rem_i  = rem_r[k-1];
				assign root_i = root_r[k-1];
				assign v_i    = v_r[k-1];
				assign meta_i = meta_r[k-1];
			end

			assign sh    = {rem_i, v_i[2*(ROOT_BITS-1-k) +: 2]};
			assign trial = {2'b00, root_i, 2'b01};

			always_ff @(posedge clk) begin
				if (en) begin
					v_r[k]    <= v_i;
					meta_r[k] <= meta_i;
					if (sh >= trial) begin
						rem_r[k]  <= 33'(sh - trial);
						root_r[k] <= {root_i[29:0], 1'b1};
					end else begin
						rem_r[k]  <= sh[32:0];
						root_r[k] <= {root_i[29:0], 1'b0};
					end
				end
			end
		end

		// Numerator is m * 2^(frac + h) plus half the divisor for rounding.
		always_ff @(posedge clk) begin
			logic [47:0] num;
			logic [5:0]  amt;
			if (en) begin
				amt = 6'(QUAT_FRAC_BITS) + 6'(meta_r[ROOT_BITS-1].h);
				for (int c = 0; c < 4; c++) begin
					num = (48'(meta_r[ROOT_BITS-1].m[c]) << amt)
						+ 48'(root_r[ROOT_BITS-1] >> 1);
					drem_s5[c] <= 32'(num >> DIV_BITS);
					nlow_s5[c] <= num[DIV_BITS-1:0];
				end
				r_s5    <= root_r[ROOT_BITS-1];
				meta_s5 <= meta_r[ROOT_BITS-1];
			end
		end

		for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
			logic [3:0][31:0] drem_i;
			logic [3:0][15:0] nlow_i;
			logic [3:0][15:0] quo_i;
			logic [30:0]      r_i;
			nmeta_t           meta_i;

			if (j == 0) begin : g_first
				assign drem_i = drem_s5;
				assign nlow_i = nlow_s5;
				assign quo_i  = '0;
				assign r_i    = r_s5;
				assign meta_i = meta_s5;
			end else begin : g_next
				assign drem_i = drem_d[j-1];
				assign nlow_i = nlow_d[j-1];
				assign quo_i  = quo_d[j-1];
				assign r_i    = r_d[j-1];
				assign meta_i = meta_d[j-1];
			end

			always_ff @(posedge clk) begin
				logic [31:0] t;
				if (en) begin
					for (int c = 0; c < 4; c++) begin
						t = {drem_i[c][30:0], nlow_i[c][DIV_BITS-1-j]};
						if (t >= 32'(r_i)) begin
							drem_d[j][c] <= t - 32'(r_i);
							quo_d[j][c]  <= {quo_i[c][14:0], 1'b1};
						end else begin
							drem_d[j][c] <= t;
							quo_d[j][c]  <= {quo_i[c][14:0], 1'b0};
						end
					end
					nlow_d[j] <= nlow_i;
					r_d[j]    <= r_i;
					meta_d[j] <= meta_i;
				end
			end
		end

		always_ff @(posedge clk) begin
			logic [15:0] qv;
			if (en) begin
				for (int c = 0; c < 4; c++) begin
					qv = (quo_d[DIV_BITS-1][c] > QUAT_ONE) ? QUAT_ONE
						: quo_d[DIV_BITS-1][c];
					if (meta_d[DIV_BITS-1].zero) out_q[l][c] <= '0;
					else if (meta_d[DIV_BITS-1].neg[c]) out_q[l][c] <= 16'(-qv);
					else out_q[l][c] <= qv;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/quaternion_attitude_pd_controller.sv =====
// Quaternion attitude PD controller, top level.
// Instantiates qapd_norm twice; uses qapd_pkg.
//
// Input transaction on s_axis: target and measured attitude quaternions
// (Q1.14) and body rates (Q5.10). Output transaction on m_axis: three
// saturated Q11.12 torques in tdata and the saturation flag in tuser.
// Gains are written on the cfg port (index 0..5, writes above 5 dropped), by
// the user only while no transaction is in flight; the block does not enforce it.
// The pipeline is 113 register stages deep: two normalizers of 53 stages each
// (31 square root stages and 16 divider stages set that depth), three error
// product stages and four torque stages. One transaction is accepted every cycle
// while the output does not stall. The pipeline advances as a whole: when m_axis
// holds a result that is not taken, s_axis_tready drops and every stage holds
// its contents, so nothing is lost or repeated. Reset clears all valid bits and
// loads the gain reset values; the block accepts a transaction in the first cycle
// after.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_attitude_pd_controller import qapd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// target_qw, target_qx, target_qy, target_qz, meas_qw, meas_qx,
	// meas_qy, meas_qz, rate_x, rate_y, rate_z (16 bit each, lowest first)
	input  wire logic [175:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// torque_x, torque_y, torque_z (24 bit each, lowest first)
	output logic [71:0]       m_axis_tdata,
	// clipped
	output logic              m_axis_tuser,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_addr,
	input  wire logic [15:0]  cfg_wdata
);

	logic [2:0][15:0] kp_q;
	logic [2:0][15:0] kd_q;
	logic             en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= {PROP_Z_RST, PROP_XY_RST, PROP_XY_RST};
			kd_q <= {DAMP_Z_RST, DAMP_XY_RST, DAMP_XY_RST};
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PROP_X: kp_q[0] <= cfg_wdata;
				REG_PROP_Y: kp_q[1] <= cfg_wdata;
				REG_PROP_Z: kp_q[2] <= cfg_wdata;
				REG_DAMP_X: kd_q[0] <= cfg_wdata;
				REG_DAMP_Y: kd_q[1] <= cfg_wdata;
				REG_DAMP_Z: kd_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Input normalization: lane 0 target, lane 1 measured.
	quat_t       n1_in  [2];
	quat_t       n1_out [2];
	logic        n1_vld;
	logic [47:0] n1_rate;

	assign n1_in[0] = s_axis_tdata[63:0];
	assign n1_in[1] = s_axis_tdata[127:64];

	qapd_norm #(.NQ(2), .SIDE_W(48)) u_norm_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_axis_tvalid),
		.in_q     (n1_in),
		.in_side  (s_axis_tdata[175:128]),
		.out_vld  (n1_vld),
		.out_q    (n1_out),
		.out_side (n1_rate)
	);

	// Error quaternion conj(meas) * target: all sixteen products, sums, then rounding and clamping.
	logic                   vld_p1, vld_p2, vld_p3;
	logic [47:0]            rate_p1, rate_p2, rate_p3;
	logic signed [31:0]     pr_p1 [4][4];
	logic signed [31:0]     sum_p2 [4];
	quat_t                  err_p3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
		end else if (en) begin
			vld_p1 <= n1_vld;
			vld_p2 <= vld_p1;
			vld_p3 <= vld_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rate_p1 <= n1_rate;
			for (int a = 0; a < 4; a++) begin
				for (int b = 0; b < 4; b++) begin
					pr_p1[a][b] <= $signed(n1_out[1][a]) * $signed(n1_out[0][b]);
				end
			end
		end
	end

	// First index is the measured component, second the target component.
	always_ff @(posedge clk) begin
		if (en) begin
			rate_p2   <= rate_p1;
			sum_p2[0] <= pr_p1[0][0] + pr_p1[1][1] + pr_p1[2][2] + pr_p1[3][3];
			sum_p2[1] <= pr_p1[0][1] - pr_p1[1][0] - pr_p1[2][3] + pr_p1[3][2];
			sum_p2[2] <= pr_p1[0][2] + pr_p1[1][3] - pr_p1[2][0] - pr_p1[3][1];
			sum_p2[3] <= pr_p1[0][3] - pr_p1[1][2] + pr_p1[2][1] - pr_p1[3][0];
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] m;
		logic [17:0] r;
		logic [15:0] c;
		if (en) begin
			rate_p3 <= rate_p2;
			for (int i = 0; i < 4; i++) begin
				m = sum_p2[i][31] ? 32'(-sum_p2[i]) : 32'(sum_p2[i]);
				r = 18'((m + 32'(1 << (QUAT_FRAC_BITS - 1))) >> QUAT_FRAC_BITS);
				c = (r > 18'(QUAT_ONE)) ? QUAT_ONE : r[15:0];
				err_p3[i] <= sum_p2[i][31] ? 16'(-c) : c;
			end
		end
	end

	quat_t       n2_in  [1];
	quat_t       n2_out [1];
	logic        n2_vld;
	logic [47:0] n2_rate;

	assign n2_in[0] = err_p3;

	qapd_norm #(.NQ(1), .SIDE_W(48)) u_norm_err (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_p3),
		.in_q     (n2_in),
		.in_side  (rate_p3),
		.out_vld  (n2_vld),
		.out_q    (n2_out),
		.out_side (n2_rate)
	);

	// Torque: sign-adjusted error, products, sum, rounding and saturation.
	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic [2:0][15:0]        ev_s1;
	logic [47:0]             rate_s1;
	logic signed [32:0]      pd_s2 [3];
	logic signed [31:0]      pp_s2 [3];
	logic signed [47:0]      acc_s3 [3];
	logic [2:0][23:0]        tq_s4;
	logic                    clip_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= n2_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [15:0] w;
		if (en) begin
			rate_s1 <= n2_rate;
			w = $signed(n2_out[0][0]);
			for (int i = 0; i < 3; i++) begin
				if (w > 0) ev_s1[i] <= n2_out[0][i+1];
				else if (w < 0) ev_s1[i] <= 16'(-n2_out[0][i+1]);
				else ev_s1[i] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pd_s2[i] <= $signed({1'b0, kd_q[i]}) * $signed(rate_s1[16*i +: 16]);
				pp_s2[i] <= 32'($signed({1'b0, kp_q[i]}) * $signed(ev_s1[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				acc_s3[i] <= (48'(pp_s2[i]) <<< RATE_FRAC_BITS)
					- (48'(pd_s2[i]) <<< QUAT_FRAC_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [47:0] m;
		logic [24:0] r;
		logic        clip;
		if (en) begin
			clip = 1'b0;
			for (int i = 0; i < 3; i++) begin
				m = acc_s3[i][47] ? 48'(-acc_s3[i]) : 48'(acc_s3[i]);
				r = 25'((m + 48'(1 << (ACC_SHIFT - 1))) >> ACC_SHIFT);
				if (acc_s3[i][47]) begin
					if (r > 25'h0800000) begin
						tq_s4[i] <= 24'h800000;
						clip = 1'b1;
					end else begin
						tq_s4[i] <= 24'(-r);
					end
				end else begin
					if (r > 25'h07FFFFF) begin
						tq_s4[i] <= 24'h7FFFFF;
						clip = 1'b1;
					end else begin
						tq_s4[i] <= r[23:0];
					end
				end
			end
			clip_s4 <= clip;
		end
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = tq_s4;
	assign m_axis_tuser  = clip_s4;

endmodule

`default_nettype wire

// ===== src/qapd_checker.sv =====
// Port-level checker for the quaternion attitude PD controller, with the
// bind that attaches it to the top level. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module qapd_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [71:0]  m_axis_tdata,
	input wire logic         m_axis_tuser
);

	// A pending result is held until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result transaction dropped while stalled");

	// The input side only stalls when a result is waiting and not taken.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output flow");

	// Once reset has been seen at an edge, no result is presented after it.
	a_reset: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

	// The clip flag implies at least one torque sits on a rail.
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[23:0] == 24'h7FFFFF || m_axis_tdata[23:0] == 24'h800000 ||
			m_axis_tdata[47:24] == 24'h7FFFFF || m_axis_tdata[47:24] == 24'h800000 ||
			m_axis_tdata[71:48] == 24'h7FFFFF || m_axis_tdata[71:48] == 24'h800000)
		else $error("clip flag without saturated torque");

endmodule

bind quaternion_attitude_pd_controller qapd_checker u_qapd_checker (.*);

`default_nettype wire
